// ===== sv/osl_pkg.sv =====
// Shared constants and types for the one-port OSL error correction core.
// No dependencies.
package osl_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_RE  = 3'd0,
        REG_OPEN_IM  = 3'd1,
        REG_SHORT_RE = 3'd2,
        REG_SHORT_IM = 3'd3,
        REG_LOAD_RE  = 3'd4,
        REG_LOAD_IM  = 3'd5
    } cfg_reg_t;

endpackage

// ===== sv/osl_if.sv =====
// Channel interfaces: sample stream in, corrected result stream out, register writes.
// Depends on osl_pkg.
interface osl_sample_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] meas_dut_re;
    logic signed [DATA_WIDTH-1:0] meas_dut_im;
    logic signed [DATA_WIDTH-1:0] meas_open_re;
    logic signed [DATA_WIDTH-1:0] meas_open_im;
    logic signed [DATA_WIDTH-1:0] meas_short_re;
    logic signed [DATA_WIDTH-1:0] meas_short_im;
    logic signed [DATA_WIDTH-1:0] meas_load_re;
    logic signed [DATA_WIDTH-1:0] meas_load_im;

    modport source (output valid, meas_dut_re, meas_dut_im, meas_open_re, meas_open_im,
                    meas_short_re, meas_short_im, meas_load_re, meas_load_im,
                    input ready);
    modport sink (input valid, meas_dut_re, meas_dut_im, meas_open_re, meas_open_im,
                  meas_short_re, meas_short_im, meas_load_re, meas_load_im,
                  output ready);
endinterface

interface osl_result_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] corrected_re;
    logic signed [DATA_WIDTH-1:0] corrected_im;
    logic                         degenerate;

    modport source (output valid, corrected_re, corrected_im, degenerate, input ready);
    modport sink (input valid, corrected_re, corrected_im, degenerate, output ready);
endinterface

interface osl_cfg_if #(parameter int DATA_WIDTH = 32);
    logic                           valid;
    logic                           ready;
    logic [osl_pkg::CFG_IDX_W-1:0]  reg_index;
    logic signed [DATA_WIDTH-1:0]   wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/osl_cmac.sv =====
// Pipelined complex multiply-accumulate of up to three terms with one rounding.
// Two stages: registered products, then sum, round half away from zero, saturate.
module osl_cmac #(
    parameter int W     = 32,
    parameter int F     = 28,
    parameter int XW    = 32,
    parameter int TERMS = 1
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [TERMS*XW-1:0]   x_re,
    input  logic [TERMS*XW-1:0]   x_im,
    input  logic [TERMS*W-1:0]    y_re,
    input  logic [TERMS*W-1:0]    y_im,
    output logic signed [W-1:0]   p_re,
    output logic signed [W-1:0]   p_im,
    output logic                  ovf
);

    localparam int PW = XW + W;
    localparam int AW = PW + 3;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic signed [PW-1:0] rr_reg [TERMS];
    logic signed [PW-1:0] ii_reg [TERMS];
    logic signed [PW-1:0] ri_reg [TERMS];
    logic signed [PW-1:0] ir_reg [TERMS];
    logic signed [AW-1:0] sum_re, sum_im;
    logic [W:0]           rnd_re, rnd_im;

    function automatic logic [W:0] rnd(input logic signed [AW-1:0] s);
        logic          neg;
        logic [AW-1:0] mag;
        logic [AW-1:0] t;
        logic [AW-1:0] lim;
        neg = s[AW-1];
        mag = neg ? AW'(-s) : AW'(s);
        t   = (mag + (AW'(1) << (F-1))) >> F;
        lim = neg ? (AW'(1) << (W-1)) : ((AW'(1) << (W-1)) - AW'(1));
        if (t > lim)
            return {1'b1, (neg ? MINV : MAXV)};
        else
            return {1'b0, (neg ? W'(~t[W-1:0] + W'(1)) : t[W-1:0])};
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < TERMS; t++)
            begin
                rr_reg[t] <= $signed(x_re[t*XW +: XW]) * $signed(y_re[t*W +: W]);
                ii_reg[t] <= $signed(x_im[t*XW +: XW]) * $signed(y_im[t*W +: W]);
                ri_reg[t] <= $signed(x_re[t*XW +: XW]) * $signed(y_im[t*W +: W]);
                ir_reg[t] <= $signed(x_im[t*XW +: XW]) * $signed(y_re[t*W +: W]);
            end
        end
    end

    always_comb
    begin
        sum_re = '0;
        sum_im = '0;
        for (int t = 0; t < TERMS; t++)
        begin
            sum_re = sum_re + AW'(rr_reg[t]) - AW'(ii_reg[t]);
            sum_im = sum_im + AW'(ri_reg[t]) + AW'(ir_reg[t]);
        end
        rnd_re = rnd(sum_re);
        rnd_im = rnd(sum_im);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_re <= rnd_re[W-1:0];
            p_im <= rnd_im[W-1:0];
            ovf  <= rnd_re[W] | rnd_im[W];
        end
    end

endmodule

// ===== sv/osl_cdiv.sv =====
// Pipelined complex divider n/d: products, |d|^2, one restoring quotient bit per stage,
// round half away from zero and saturate.
module osl_cdiv #(
    parameter int W = 32,
    parameter int F = 28
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] n_re,
    input  logic signed [W-1:0] n_im,
    input  logic signed [W-1:0] d_re,
    input  logic signed [W-1:0] d_im,
    output logic signed [W-1:0] q_re,
    output logic signed [W-1:0] q_im,
    output logic                ovf
);

    localparam int PW = 2 * W;
    localparam int CW = 3 * W + F;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic signed [PW-1:0] m_reg [6];
    logic signed [PW:0]   num [2];
    logic signed [PW:0]   den_s;
    logic                 neg_reg [2];
    logic [PW-1:0]        mag_reg [2];
    logic [PW-1:0]        den2_reg;

    logic [PW-1:0]        den_reg [0:W];
    logic [CW-1:0]        rem_reg [2][0:W];
    logic [W-1:0]         quo_reg [2][0:W];
    logic                 sg_reg  [2][0:W];
    logic                 ov_reg  [2][0:W];
    logic                 zd_reg  [2][0:W];
    logic                 mz_reg  [2][0:W];

    logic [CW-1:0]        dsh [1:W];
    logic                 ge  [2][1:W];
    logic [W:0]           q1  [2];
    logic [W:0]           lim [2];
    logic signed [W-1:0]  res [2];
    logic                 bad [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= n_re * d_re;
            m_reg[1] <= n_im * d_im;
            m_reg[2] <= n_im * d_re;
            m_reg[3] <= n_re * d_im;
            m_reg[4] <= d_re * d_re;
            m_reg[5] <= d_im * d_im;
        end
    end

    always_comb
    begin
        num[0] = (PW+1)'(m_reg[0]) + (PW+1)'(m_reg[1]);
        num[1] = (PW+1)'(m_reg[2]) - (PW+1)'(m_reg[3]);
        den_s  = (PW+1)'(m_reg[4]) + (PW+1)'(m_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                neg_reg[l] <= num[l][PW];
                mag_reg[l] <= num[l][PW] ? PW'(-num[l]) : PW'(num[l]);
            end
            den2_reg <= den_s[PW-1:0];
        end
    end

    always_comb
    begin
        for (int s = 1; s <= W; s++)
        begin
            dsh[s] = CW'(den_reg[s-1]) << (W - s);
            for (int l = 0; l < 2; l++)
                ge[l][s] = rem_reg[l][s-1] >= dsh[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den2_reg;
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[l][0] <= CW'({mag_reg[l], {F{1'b0}}});
                quo_reg[l][0] <= '0;
                sg_reg[l][0]  <= neg_reg[l];
                ov_reg[l][0]  <= CW'({mag_reg[l], {F{1'b0}}}) >= CW'({den2_reg, {W{1'b0}}});
                zd_reg[l][0]  <= (den2_reg == '0);
                mz_reg[l][0]  <= (mag_reg[l] == '0);
            end
            for (int s = 1; s <= W; s++)
            begin
                den_reg[s] <= den_reg[s-1];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[l][s] <= ge[l][s] ? rem_reg[l][s-1] - dsh[s] : rem_reg[l][s-1];
                    quo_reg[l][s] <= quo_reg[l][s-1] | (W'(ge[l][s]) << (W - s));
                    sg_reg[l][s]  <= sg_reg[l][s-1];
                    ov_reg[l][s]  <= ov_reg[l][s-1];
                    zd_reg[l][s]  <= zd_reg[l][s-1];
                    mz_reg[l][s]  <= mz_reg[l][s-1];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            q1[l]  = (W+1)'(quo_reg[l][W])
                   + (W+1)'(({rem_reg[l][W][PW-1:0], 1'b0}) >= (PW+1)'(den_reg[W]));
            lim[l] = sg_reg[l][W] ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - (W+1)'(1));
            if (zd_reg[l][W])
            begin
                bad[l] = 1'b1;
                res[l] = mz_reg[l][W] ? '0 : (sg_reg[l][W] ? MINV : MAXV);
            end
            else if (ov_reg[l][W] || (q1[l] > lim[l]))
            begin
                bad[l] = 1'b1;
                res[l] = sg_reg[l][W] ? MINV : MAXV;
            end
            else
            begin
                bad[l] = 1'b0;
                res[l] = sg_reg[l][W] ? W'(~q1[l][W-1:0] + W'(1)) : q1[l][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_re <= res[0];
            q_im <= res[1];
            ovf  <= bad[0] | bad[1];
        end
    end

endmodule

// ===== sv/one_port_osl_error_correction_core.sv =====
// One-port open/short/load error correction core (three-term error model).
// Depends on osl_pkg, osl_if, osl_cmac and osl_cdiv.
//
// Usage:
//   sample : one beat per frequency point: measured device reflection and the measured
//            open, short and load reflections, all signed fixed point (FRAC_BITS fraction).
//   result : one beat per sample: corrected reflection, saturated, and a degenerate flag
//            set when a denominator was zero or any intermediate saturated.
//   cfg    : writes the true open/short/load reflections (indexes 0..5, others ignored).
//            Write only while the pipeline is empty; cfg.ready is always high.
// Throughput: one sample per cycle while the output does not stall. The pipeline runs
// through the two chained complex dividers, each producing one quotient bit per stage.
// Reset loads open = +1, short = -1, load = 0 and empties the pipeline.
// When result.ready is low with a beat waiting, the whole pipeline holds and
// sample.ready drops in the same cycle; nothing is lost or repeated.
module one_port_osl_error_correction_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  logic         clk,
    input  logic         rst_n,
    osl_sample_if.sink   sample,
    osl_result_if.source result,
    osl_cfg_if.sink      cfg
);

    import osl_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int DL = W + 4;
    localparam int TA = 6 + DL;
    localparam int TE = TA + 2;
    localparam int TQ = TE + DL;
    localparam int NS = TQ + 1;

    localparam logic signed [W-1:0]   MAXV   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   MINV   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W+1:0]   MAXX   = (W+2)'(MAXV);
    localparam logic signed [W+1:0]   MINX   = (W+2)'(MINV);
    localparam logic signed [W-1:0]   QONE   = {{(W-1){1'b0}}, 1'b1} << F;

    logic signed [W-1:0] so_re_reg, so_im_reg, ss_re_reg, ss_im_reg, sl_re_reg, sl_im_reg;

    logic          en;
    logic          fire;
    logic [NS:1]   v_reg;
    logic [NS:1]   b_reg;
    logic [NS-1:0] ev;

    logic [W:0]          ck_re [3];
    logic [W:0]          ck_im [3];
    logic signed [W-1:0] k_re_reg [3];
    logic signed [W-1:0] k_im_reg [3];
    logic signed [W-1:0] kd_re_reg [3];
    logic signed [W-1:0] kd_im_reg [3];
    logic [6*W-1:0]      std_reg [1:4];
    logic [2*W-1:0]      mm_reg [1:TA];

    logic signed [W-1:0] pa_re [3], pa_im [3], pb_re [3], pb_im [3];
    logic signed [W-1:0] p_re [3], p_im [3];
    logic signed [W-1:0] ka_re [3], ka_im [3];
    logic signed [W-1:0] kh_re [3], kh_im [3];
    logic signed [W-1:0] kl_re [3], kl_im [3];
    logic [2:0]          p_ovf, kh_ovf, kl_ovf;

    logic [W:0]          cn_c_re, cn_c_im, d_c_re, d_c_im;
    logic signed [W-1:0] cn_re_reg [3], cn_im_reg [3];
    logic signed [W-1:0] d_re_reg [2], d_im_reg [2];
    logic signed [W-1:0] an_re, an_im, bn_re, bn_im;
    logic                an_ovf, bn_ovf;
    logic signed [W-1:0] an_re_reg, an_im_reg;

    logic signed [W-1:0] dn_re [3], dn_im [3];
    logic signed [W-1:0] q_re [3], q_im [3];
    logic [2:0]          q_ovf;

    logic [W:0]          nr_c_re, nr_c_im;
    logic signed [W-1:0] nr_re_reg [2], nr_im_reg [2];
    logic signed [W:0]   ar_x_re, ar_x_im, ncr_re, ncr_im;
    logic signed [W-1:0] er_re, er_im;
    logic                er_ovf;
    logic signed [W-1:0] fq_re, fq_im;
    logic                fq_ovf;
    logic signed [W-1:0] corr_re_reg, corr_im_reg;

    function automatic logic [W:0] clip(input logic signed [W+1:0] v);
        if (v > MAXX)
            return {1'b1, MAXV};
        else if (v < MINX)
            return {1'b1, MINV};
        else
            return {1'b0, v[W-1:0]};
    endfunction

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            so_re_reg <= QONE;
            so_im_reg <= '0;
            ss_re_reg <= -QONE;
            ss_im_reg <= '0;
            sl_re_reg <= '0;
            sl_im_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_OPEN_RE:  so_re_reg <= cfg.wdata;
                REG_OPEN_IM:  so_im_reg <= cfg.wdata;
                REG_SHORT_RE: ss_re_reg <= cfg.wdata;
                REG_SHORT_IM: ss_im_reg <= cfg.wdata;
                REG_LOAD_RE:  sl_re_reg <= cfg.wdata;
                REG_LOAD_IM:  sl_im_reg <= cfg.wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign en           = !v_reg[NS] || result.ready;
    assign sample.ready = en;
    assign fire         = sample.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            b_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-1:1], fire};
            b_reg <= {b_reg[NS-1:1] | ev[NS-1:1], ev[0]};
        end
    end

    always_comb
    begin
        ev     = '0;
        ev[0]  = ck_re[0][W] | ck_re[1][W] | ck_re[2][W]
               | ck_im[0][W] | ck_im[1][W] | ck_im[2][W];
        ev[2]  = |p_ovf;
        ev[3]  = (|kh_ovf) | cn_c_re[W] | cn_c_im[W];
        ev[4]  = (|kl_ovf) | d_c_re[W] | d_c_im[W];
        ev[5]  = an_ovf;
        ev[6]  = bn_ovf;
        ev[TA] = (|q_ovf) | nr_c_re[W] | nr_c_im[W];
        ev[TE] = er_ovf;
        ev[TQ] = fq_ovf;
    end

    // K1 = Ml-Ms, K2 = Ms-Mo, K3 = Mo-Ml
    always_comb
    begin
        ck_re[0] = clip((W+2)'(sample.meas_load_re) - (W+2)'(sample.meas_short_re));
        ck_im[0] = clip((W+2)'(sample.meas_load_im) - (W+2)'(sample.meas_short_im));
        ck_re[1] = clip((W+2)'(sample.meas_short_re) - (W+2)'(sample.meas_open_re));
        ck_im[1] = clip((W+2)'(sample.meas_short_im) - (W+2)'(sample.meas_open_im));
        ck_re[2] = clip((W+2)'(sample.meas_open_re) - (W+2)'(sample.meas_load_re));
        ck_im[2] = clip((W+2)'(sample.meas_open_im) - (W+2)'(sample.meas_load_im));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                k_re_reg[i]  <= ck_re[i][W-1:0];
                k_im_reg[i]  <= ck_im[i][W-1:0];
                kd_re_reg[i] <= k_re_reg[i];
                kd_im_reg[i] <= k_im_reg[i];
            end
            std_reg[1] <= {sample.meas_open_re, sample.meas_open_im,
                           sample.meas_load_re, sample.meas_load_im,
                           sample.meas_short_re, sample.meas_short_im};
            for (int s = 2; s <= 4; s++)
                std_reg[s] <= std_reg[s-1];
            mm_reg[1] <= {sample.meas_dut_re, sample.meas_dut_im};
            for (int s = 2; s <= TA; s++)
                mm_reg[s] <= mm_reg[s-1];

            cn_re_reg[0] <= cn_c_re[W-1:0];
            cn_im_reg[0] <= cn_c_im[W-1:0];
            cn_re_reg[1] <= cn_re_reg[0];
            cn_im_reg[1] <= cn_im_reg[0];
            cn_re_reg[2] <= cn_re_reg[1];
            cn_im_reg[2] <= cn_im_reg[1];
            d_re_reg[0]  <= d_c_re[W-1:0];
            d_im_reg[0]  <= d_c_im[W-1:0];
            d_re_reg[1]  <= d_re_reg[0];
            d_im_reg[1]  <= d_im_reg[0];
            an_re_reg    <= an_re;
            an_im_reg    <= an_im;

            nr_re_reg[0] <= nr_c_re[W-1:0];
            nr_im_reg[0] <= nr_c_im[W-1:0];
            nr_re_reg[1] <= nr_re_reg[0];
            nr_im_reg[1] <= nr_im_reg[0];

            corr_re_reg  <= fq_re;
            corr_im_reg  <= fq_im;
        end
    end

    // standards products Sl*Ss, So*Ss, Sl*So; then K7..K9 and K4..K6
    always_comb
    begin
        pa_re[0] = sl_re_reg; pa_im[0] = sl_im_reg; pb_re[0] = ss_re_reg; pb_im[0] = ss_im_reg;
        pa_re[1] = so_re_reg; pa_im[1] = so_im_reg; pb_re[1] = ss_re_reg; pb_im[1] = ss_im_reg;
        pa_re[2] = sl_re_reg; pa_im[2] = sl_im_reg; pb_re[2] = so_re_reg; pb_im[2] = so_im_reg;
        ka_re[0] = so_re_reg; ka_im[0] = so_im_reg;
        ka_re[1] = sl_re_reg; ka_im[1] = sl_im_reg;
        ka_re[2] = ss_re_reg; ka_im[2] = ss_im_reg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_terms
        osl_cmac #(.W(W), .F(F), .XW(W), .TERMS(1)) u_p (
            .clk(clk), .en(en),
            .x_re(pa_re[i]), .x_im(pa_im[i]), .y_re(pb_re[i]), .y_im(pb_im[i]),
            .p_re(p_re[i]), .p_im(p_im[i]), .ovf(p_ovf[i])
        );
        osl_cmac #(.W(W), .F(F), .XW(W), .TERMS(1)) u_kh (
            .clk(clk), .en(en),
            .x_re(ka_re[i]), .x_im(ka_im[i]), .y_re(k_re_reg[i]), .y_im(k_im_reg[i]),
            .p_re(kh_re[i]), .p_im(kh_im[i]), .ovf(kh_ovf[i])
        );
        osl_cmac #(.W(W), .F(F), .XW(W), .TERMS(1)) u_kl (
            .clk(clk), .en(en),
            .x_re(kd_re_reg[i]), .x_im(kd_im_reg[i]), .y_re(p_re[i]), .y_im(p_im[i]),
            .p_re(kl_re[i]), .p_im(kl_im[i]), .ovf(kl_ovf[i])
        );
    end

    always_comb
    begin
        cn_c_re = clip((W+2)'(kh_re[0]) + (W+2)'(kh_re[1]) + (W+2)'(kh_re[2]));
        cn_c_im = clip((W+2)'(kh_im[0]) + (W+2)'(kh_im[1]) + (W+2)'(kh_im[2]));
        d_c_re  = clip((W+2)'(kl_re[0]) + (W+2)'(kl_re[1]) + (W+2)'(kl_re[2]));
        d_c_im  = clip((W+2)'(kl_im[0]) + (W+2)'(kl_im[1]) + (W+2)'(kl_im[2]));
    end

    // Anum = Mo*K7 + Ml*K8 + Ms*K9, Bnum = Mo*K4 + Ml*K5 + Ms*K6
    osl_cmac #(.W(W), .F(F), .XW(W), .TERMS(3)) u_anum (
        .clk(clk), .en(en),
        .x_re({std_reg[3][2*W-1 -: W], std_reg[3][4*W-1 -: W], std_reg[3][6*W-1 -: W]}),
        .x_im({std_reg[3][W-1 -: W], std_reg[3][3*W-1 -: W], std_reg[3][5*W-1 -: W]}),
        .y_re({kh_re[2], kh_re[1], kh_re[0]}),
        .y_im({kh_im[2], kh_im[1], kh_im[0]}),
        .p_re(an_re), .p_im(an_im), .ovf(an_ovf)
    );

    osl_cmac #(.W(W), .F(F), .XW(W), .TERMS(3)) u_bnum (
        .clk(clk), .en(en),
        .x_re({std_reg[4][2*W-1 -: W], std_reg[4][4*W-1 -: W], std_reg[4][6*W-1 -: W]}),
        .x_im({std_reg[4][W-1 -: W], std_reg[4][3*W-1 -: W], std_reg[4][5*W-1 -: W]}),
        .y_re({kl_re[2], kl_re[1], kl_re[0]}),
        .y_im({kl_im[2], kl_im[1], kl_im[0]}),
        .p_re(bn_re), .p_im(bn_im), .ovf(bn_ovf)
    );

    // A, B, C = Anum/D, Bnum/D, Cnum/D
    always_comb
    begin
        dn_re[0] = an_re_reg;    dn_im[0] = an_im_reg;
        dn_re[1] = bn_re;        dn_im[1] = bn_im;
        dn_re[2] = cn_re_reg[2]; dn_im[2] = cn_im_reg[2];
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_abc
        osl_cdiv #(.W(W), .F(F)) u_div (
            .clk(clk), .en(en),
            .n_re(dn_re[i]), .n_im(dn_im[i]), .d_re(d_re_reg[1]), .d_im(d_im_reg[1]),
            .q_re(q_re[i]), .q_im(q_im[i]), .ovf(q_ovf[i])
        );
    end

    // numerator Mdut - B, denominator A - C*Mdut
    always_comb
    begin
        nr_c_re = clip((W+2)'($signed(mm_reg[TA][2*W-1 -: W])) - (W+2)'(q_re[1]));
        nr_c_im = clip((W+2)'($signed(mm_reg[TA][W-1 -: W])) - (W+2)'(q_im[1]));
        ar_x_re = (W+1)'(q_re[0]);
        ar_x_im = (W+1)'(q_im[0]);
        ncr_re  = -((W+1)'(q_re[2]));
        ncr_im  = -((W+1)'(q_im[2]));
    end

    osl_cmac #(.W(W), .F(F), .XW(W+1), .TERMS(2)) u_den (
        .clk(clk), .en(en),
        .x_re({ncr_re, ar_x_re}),
        .x_im({ncr_im, ar_x_im}),
        .y_re({mm_reg[TA][2*W-1 -: W], QONE}),
        .y_im({mm_reg[TA][W-1 -: W], {W{1'b0}}}),
        .p_re(er_re), .p_im(er_im), .ovf(er_ovf)
    );

    osl_cdiv #(.W(W), .F(F)) u_fdiv (
        .clk(clk), .en(en),
        .n_re(nr_re_reg[1]), .n_im(nr_im_reg[1]), .d_re(er_re), .d_im(er_im),
        .q_re(fq_re), .q_im(fq_im), .ovf(fq_ovf)
    );

    assign result.valid        = v_reg[NS];
    assign result.corrected_re = corr_re_reg;
    assign result.corrected_im = corr_im_reg;
    assign result.degenerate   = b_reg[NS];

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> v_reg[1])
        else $error("accepted beat did not enter the pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg) && $stable(b_reg))
        else $error("pipeline moved during a stall");

    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NS] && !result.ready) |-> !sample.ready)
        else $error("input accepted while output stalled");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for one_port_osl_error_correction_core: directed table plus
// random sweep points, checked against table entries or an in-bench fixed-point predictor.
// Depends on osl_pkg, the interfaces in osl_if and one_port_osl_error_correction_core.
`timescale 1ns / 100ps

module tb;
    import osl_pkg::*;

    localparam int DW = 32;
    localparam int FB = 28;
    localparam int LAT = 2 * DW + 17;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam logic signed [DW-1:0] ONE  = 32'sh1000_0000;
    localparam logic signed [DW-1:0] MONE = -32'sh1000_0000;
    localparam logic signed [DW-1:0] HALF = 32'sh0800_0000;
    localparam logic signed [DW-1:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [DW-1:0] MINV = 32'sh8000_0000;
    localparam logic signed [DW-1:0] ALTA = 32'shaaaa_aaaa;
    localparam logic signed [DW-1:0] ALT5 = 32'sh5555_5555;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint QONE = 64'sd1 << FB;

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        logic signed [DW-1:0] dut_re, dut_im, open_re, open_im;
        logic signed [DW-1:0] short_re, short_im, load_re, load_im;
    } point_t;

    typedef struct packed {
        logic signed [DW-1:0] re, im;
        logic                 deg;
    } corr_t;

    typedef struct packed {
        point_t pt;
        logic   typed;
        corr_t  corr;
    } dir_row_t;

    localparam int NDIR = 14;
    dir_row_t dir_tab [NDIR] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1'b1}},
        '{'{MAXV, MAXV, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1'b1}},
        '{'{MINV, MINV, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1'b1}},
        '{'{HALF, 0, ONE, 0, MONE, 0, 0, 0}, 1'b0, '{0, 0, 1'b0}},
        '{'{0, HALF, ONE, 0, MONE, 0, 0, 0}, 1'b0, '{0, 0, 1'b0}},
        '{'{ONE, 0, ONE, 0, MONE, 0, 0, 0}, 1'b0, '{0, 0, 1'b0}},
        '{'{MONE, 0, ONE, 0, MONE, 0, 0, 0}, 1'b0, '{0, 0, 1'b0}},
        '{'{0, 0, ONE, 0, MONE, 0, 0, 0}, 1'b0, '{0, 0, 1'b0}},
        '{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1'b0, '{0, 0, 1'b0}},
        '{'{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}, 1'b0, '{0, 0, 1'b0}},
        '{'{HALF, HALF, MAXV, MAXV, MINV, MINV, 0, 0}, 1'b0, '{0, 0, 1'b0}},
        '{'{ALTA, ALT5, ALT5, ALTA, ALTA, ALT5, ALT5, ALTA}, 1'b0, '{0, 0, 1'b0}},
        '{'{HALF, 0, ONE, HALF, ONE, HALF, 0, 0}, 1'b0, '{0, 0, 1'b0}},
        '{'{MONE, MONE, HALF, 0, -HALF, 0, 32'sh0199_999a, 0}, 1'b0, '{0, 0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    osl_sample_if #(.DATA_WIDTH(DW)) smp ();
    osl_result_if #(.DATA_WIDTH(DW)) res ();
    osl_cfg_if    #(.DATA_WIDTH(DW)) cfg ();

    one_port_osl_error_correction_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg)
    );

    longint std_true [6];
    bit     sat_hit;
    corr_t  corr_q [$];
    bit     gaps_on;
    bit     stalls_on;
    bit     hold_req;
    int     n_pts, n_checked, n_deg, n_err, idle_cnt;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic longint clamp(longint v);
        if (v > VMAX) begin sat_hit = 1'b1; return VMAX; end
        if (v < VMIN) begin sat_hit = 1'b1; return VMIN; end
        return v;
    endfunction

    function automatic wide_t mul(longint a, longint b);
        return wide_t'(a) * wide_t'(b);
    endfunction

    function automatic wide_t cre(longint xr, longint xi, longint yr, longint yi);
        return mul(xr, yr) - mul(xi, yi);
    endfunction

    function automatic wide_t cim(longint xr, longint xi, longint yr, longint yi);
        return mul(xr, yi) + mul(xi, yr);
    endfunction

    function automatic longint sat_mag(bit neg, wide_t m);
        wide_t lim;
        lim = neg ? wide_t'(VMAX) + 1 : wide_t'(VMAX);
        if (m > lim) begin
            sat_hit = 1'b1;
            return neg ? VMIN : VMAX;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint rnd(wide_t x);
        bit    neg;
        wide_t m;
        neg = x < 0;
        m = neg ? -x : x;
        m = (m + (wide_t'(1) <<< (FB - 1))) >>> FB;
        return sat_mag(neg, m);
    endfunction

    function automatic longint qdiv(wide_t num, wide_t den);
        wide_t m, q, rm;
        m = (num < 0 ? -num : num) <<< FB;
        q = m / den;
        rm = m % den;
        if (2 * rm >= den) q = q + 1;
        return sat_mag(num < 0, q);
    endfunction

    task automatic cdiv(input longint nr, ni, dr, di, output longint qr, qi);
        wide_t den, numr, numi;
        den = mul(dr, dr) + mul(di, di);
        numr = mul(nr, dr) + mul(ni, di);
        numi = mul(ni, dr) - mul(nr, di);
        if (den == 0) begin
            sat_hit = 1'b1;
            qr = numr == 0 ? 0 : (numr < 0 ? VMIN : VMAX);
            qi = numi == 0 ? 0 : (numi < 0 ? VMIN : VMAX);
        end else begin
            qr = qdiv(numr, den);
            qi = qdiv(numi, den);
        end
    endtask

    task automatic cmul(input longint xr, xi, yr, yi, output longint pr, pi);
        pr = rnd(cre(xr, xi, yr, yi));
        pi = rnd(cim(xr, xi, yr, yi));
    endtask

    task automatic correct_point(input point_t p, output corr_t c);
        longint mmr, mmi, mor, moi, msr, msi, mlr, mli;
        longint sor, soi, ssr, ssi, slr, sli;
        longint k1r, k1i, k2r, k2i, k3r, k3i, pr, pi;
        longint k4r, k4i, k5r, k5i, k6r, k6i, k7r, k7i, k8r, k8i, k9r, k9i;
        longint dr, di, anr, ani, bnr, bni, cnr, cni;
        longint ar, ai, br, bi, cr, ci, nr, ni, er, ei, qr, qi;
        mmr = p.dut_re;   mmi = p.dut_im;
        mor = p.open_re;  moi = p.open_im;
        msr = p.short_re; msi = p.short_im;
        mlr = p.load_re;  mli = p.load_im;
        sor = std_true[REG_OPEN_RE];  soi = std_true[REG_OPEN_IM];
        ssr = std_true[REG_SHORT_RE]; ssi = std_true[REG_SHORT_IM];
        slr = std_true[REG_LOAD_RE];  sli = std_true[REG_LOAD_IM];
        sat_hit = 1'b0;
        k1r = clamp(mlr - msr); k1i = clamp(mli - msi);
        k2r = clamp(msr - mor); k2i = clamp(msi - moi);
        k3r = clamp(mor - mlr); k3i = clamp(moi - mli);
        cmul(slr, sli, ssr, ssi, pr, pi);
        cmul(k1r, k1i, pr, pi, k4r, k4i);
        cmul(sor, soi, ssr, ssi, pr, pi);
        cmul(k2r, k2i, pr, pi, k5r, k5i);
        cmul(slr, sli, sor, soi, pr, pi);
        cmul(k3r, k3i, pr, pi, k6r, k6i);
        cmul(sor, soi, k1r, k1i, k7r, k7i);
        cmul(slr, sli, k2r, k2i, k8r, k8i);
        cmul(ssr, ssi, k3r, k3i, k9r, k9i);
        dr = clamp(k4r + k5r + k6r);  di = clamp(k4i + k5i + k6i);
        cnr = clamp(k7r + k8r + k9r); cni = clamp(k7i + k8i + k9i);
        anr = rnd(cre(mor, moi, k7r, k7i) + cre(mlr, mli, k8r, k8i)
                  + cre(msr, msi, k9r, k9i));
        ani = rnd(cim(mor, moi, k7r, k7i) + cim(mlr, mli, k8r, k8i)
                  + cim(msr, msi, k9r, k9i));
        bnr = rnd(cre(mor, moi, k4r, k4i) + cre(mlr, mli, k5r, k5i)
                  + cre(msr, msi, k6r, k6i));
        bni = rnd(cim(mor, moi, k4r, k4i) + cim(mlr, mli, k5r, k5i)
                  + cim(msr, msi, k6r, k6i));
        cdiv(anr, ani, dr, di, ar, ai);
        cdiv(bnr, bni, dr, di, br, bi);
        cdiv(cnr, cni, dr, di, cr, ci);
        nr = clamp(mmr - br); ni = clamp(mmi - bi);
        er = rnd(cre(ar, ai, QONE, 0) + cre(-cr, -ci, mmr, mmi));
        ei = rnd(cim(ar, ai, QONE, 0) + cim(-cr, -ci, mmr, mmi));
        cdiv(nr, ni, er, ei, qr, qi);
        c.re = qr[DW-1:0];
        c.im = qi[DW-1:0];
        c.deg = sat_hit;
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic logic signed [DW-1:0] jit(int amp);
        return $signed($urandom_range(0, 2 * amp)) - amp;
    endfunction

    function automatic point_t rand_point();
        point_t p;
        int     amp;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) < 8) begin
            amp = 1 << $urandom_range(10, 26);
            p.open_re  = ONE + jit(amp);  p.open_im  = jit(amp);
            p.short_re = MONE + jit(amp); p.short_im = jit(amp);
            p.load_re  = jit(amp);        p.load_im  = jit(amp);
            if ($urandom_range(0, 3) != 0) begin
                p.dut_re = jit(1 << 28);
                p.dut_im = jit(1 << 28);
            end
        end
        return p;
    endfunction

    task automatic send_point(input point_t p, input corr_t typed_c, input bit typed);
        corr_t c;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        smp.valid <= 1'b1;
        {smp.meas_dut_re, smp.meas_dut_im, smp.meas_open_re, smp.meas_open_im,
         smp.meas_short_re, smp.meas_short_im, smp.meas_load_re, smp.meas_load_im} <= p;
        do @(posedge clk); while (!smp.ready);
        correct_point(p, c);
        if (typed && c != typed_c)
            $display("%0t predictor disagrees with table: table %h pred %h",
                     $realtime, typed_c, c);
        corr_q.push_back(typed ? typed_c : c);
        n_pts++;
    endtask

    task automatic send_random(int count);
        corr_t none;
        none = '0;
        repeat (count) send_point(rand_point(), none, 1'b0);
        smp.valid <= 1'b0;
    endtask

    task automatic write_std(input logic [CFG_IDX_W-1:0] idx, input logic signed [DW-1:0] v);
        cfg.valid <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wdata <= v;
        do @(posedge clk); while (!cfg.ready);
        if (idx <= REG_LOAD_IM) std_true[idx] = v;
    endtask

    task automatic load_stds(input logic signed [DW-1:0] o_re, o_im, s_re, s_im, l_re, l_im);
        write_std(REG_OPEN_RE, o_re);
        write_std(REG_OPEN_IM, o_im);
        write_std(REG_SHORT_RE, s_re);
        write_std(REG_SHORT_IM, s_im);
        write_std(REG_LOAD_RE, l_re);
        write_std(REG_LOAD_IM, l_im);
        write_std(REG_NONE, $urandom);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (corr_q.size() != 0) @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
    endtask

    // ---------------- result side ----------------
    initial begin
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin
        corr_t want;
        if (rst_n) begin
            if ((smp.valid && smp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("%0t watchdog: no beat for %0d cycles", $realtime, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            if (res.valid && res.ready) begin
                if (corr_q.size() == 0) begin
                    $display("%0t unexpected beat: got %h %h %b", $realtime,
                             res.corrected_re, res.corrected_im, res.degenerate);
                    n_err++;
                end else begin
                    want = corr_q.pop_front();
                    n_checked++;
                    if (res.degenerate) n_deg++;
                    if (res.corrected_re !== want.re) begin
                        $display("%0t corrected_re: exp %h got %h", $realtime,
                                 want.re, res.corrected_re);
                        n_err++;
                    end
                    if (res.corrected_im !== want.im) begin
                        $display("%0t corrected_im: exp %h got %h", $realtime,
                                 want.im, res.corrected_im);
                        n_err++;
                    end
                    if (res.degenerate !== want.deg) begin
                        $display("%0t degenerate: exp %b got %b", $realtime,
                                 want.deg, res.degenerate);
                        n_err++;
                    end
                end
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        rst_n = 1'b0;
        smp.valid = 1'b0;
        {smp.meas_dut_re, smp.meas_dut_im, smp.meas_open_re, smp.meas_open_im,
         smp.meas_short_re, smp.meas_short_im, smp.meas_load_re, smp.meas_load_im} = '0;
        cfg.valid = 1'b0;
        cfg.reg_index = REG_OPEN_RE;
        cfg.wdata = '0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        hold_req = 1'b0;
        n_pts = 0; n_checked = 0; n_deg = 0; n_err = 0; idle_cnt = 0;
        std_true = '{QONE, 0, -QONE, 0, 0, 0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset standards
        for (int i = 0; i < NDIR; i++)
            send_point(dir_tab[i].pt, dir_tab[i].corr, dir_tab[i].typed);
        smp.valid <= 1'b0;
        drain();

        // realistic standards; output held off to back up the pipeline
        load_stds(ONE + jit(1 << 22), jit(1 << 22), MONE + jit(1 << 22),
                  jit(1 << 22), jit(1 << 20), jit(1 << 20));
        hold_req = 1'b1;
        gaps_on = 1'b0;
        send_random(40);
        gaps_on = 1'b1;
        send_random(60);
        drain();

        load_stds(MAXV, MINV, MINV, MAXV, MAXV, MINV);
        send_random(60);
        drain();

        load_stds(0, 0, 0, 0, 0, 0);
        send_random(40);
        drain();

        load_stds(ONE - HALF, HALF, MONE + HALF, -HALF, 32'sh0100_0000, -32'sh0100_0000);
        send_random(150);
        drain();

        load_stds(ONE, 0, MONE, 0, 0, 0);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_random(80);

        while (corr_q.size() != 0) @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
        $display("Checked %0d of %0d sweep points (%0d flagged degenerate) over six",
                 n_checked, n_pts, n_deg);
        $display("calibration settings incl. reset, extreme and all-zero standards.");
        if (n_err == 0 && corr_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/osl_pkg.sv
sv/osl_if.sv
sv/osl_cmac.sv
sv/osl_cdiv.sv
sv/one_port_osl_error_correction_core.sv
verif/tb.sv
